// ===== src/thermal_charge_current_limiter_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the thermal charge current limiter
// Implication checks, same cycle and next cycle, compiled out by NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef THERMAL_CHARGE_CURRENT_LIMITER_TOP_ASSERT_SVH
`define THERMAL_CHARGE_CURRENT_LIMITER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TCCL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tccl: same-cycle check failed");
`define TCCL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tccl: next-cycle check failed");
`else
`define TCCL_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TCCL_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/tccl_pkg.sv =====
// ---------------------------------------------------------------------------
// tccl_pkg
// Types and constants shared by the thermal charge current limiter.
// ---------------------------------------------------------------------------
`default_nettype none

package tccl_pkg;

	localparam logic [9:0] KELVIN_OFFSET = 10'd273;
	localparam logic [9:0] VALID_LOW_K   = 10'd244;
	localparam logic [9:0] VALID_HIGH_K  = 10'd397;

	localparam logic signed [7:0] RISE_ZONE3 = 8'sd60;
	localparam logic signed [7:0] RISE_ZONE2 = 8'sd55;
	localparam logic signed [7:0] RISE_ZONE1 = 8'sd50;
	localparam logic signed [7:0] FALL_ZONE1 = 8'sd45;
	localparam logic signed [7:0] FALL_ZONE2 = 8'sd50;
	localparam logic signed [7:0] FALL_ZONE3 = 8'sd55;

	localparam logic [2:0] ZONE_NONE   = 3'd0;
	localparam logic [2:0] ZONE_ONE    = 3'd1;
	localparam logic [2:0] ZONE_TWO    = 3'd2;
	localparam logic [2:0] ZONE_THREE  = 3'd3;
	localparam logic [2:0] ZONE_CUTOFF = 3'd4;

	localparam logic [2:0] REG_ZONE_ONE   = 3'd0;
	localparam logic [2:0] REG_ZONE_TWO   = 3'd1;
	localparam logic [2:0] REG_ZONE_THREE = 3'd2;
	localparam logic [2:0] REG_CPU_GATE   = 3'd3;
	localparam logic [2:0] REG_CUTOFF     = 3'd4;

	localparam logic [15:0] RST_ZONE_ONE   = 16'd2500;
	localparam logic [15:0] RST_ZONE_TWO   = 16'd1800;
	localparam logic [15:0] RST_ZONE_THREE = 16'd1000;
	localparam logic signed [7:0] RST_CPU_GATE = 8'sd43;
	localparam logic signed [7:0] RST_CUTOFF   = 8'sd79;

	typedef logic signed [7:0] celsius_t;

	typedef struct packed {
		logic [9:0]  cpu_kelvin;
		logic        bad_temperature;
		logic        system_running;
		logic        discharging;
		logic [15:0] charge_request;
		logic        take;
	} item_t;

endpackage

`default_nettype wire

// ===== src/thermal_charge_current_limiter_top.sv =====
// ---------------------------------------------------------------------------
// thermal_charge_current_limiter_top
// Charger thermal limiter: windowed charger temperature sets a heat zone
// and caps or stops the charge current.
//
// Input channel in_valid/in_ready carries one item per handshake; output
// channel out_valid/out_ready returns exactly one item per input item, in
// order. An item is accepted every cycle while the output is drained.
// From input handshake to out_valid an item passes through the window
// update and cell-chain sum, reciprocal-multiply divide, then zoning into
// the output register. The whole pipeline holds when out_ready is low and
// a result is pending; in_ready drops for as long as that stall lasts.
// Valid charger samples shift into a row of WINDOW_LENGTH cells; the sum is
// carried along the row. Reset clears every cell, the previous average and
// all valid bits, and loads the zone registers with their defaults.
// The APB port writes the five registers at byte addresses 0 to 16; the user
// must write them only while the pipeline is empty, which the block does not enforce.
// ---------------------------------------------------------------------------
`default_nettype none
`include "thermal_charge_current_limiter_top_assert.svh"

module thermal_charge_current_limiter_top #(
	parameter int WINDOW_LENGTH = 5
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [9:0]  charger_kelvin,
	input  wire  [9:0]  cpu_kelvin,
	input  wire         battery_responsive,
	input  wire         bad_temperature,
	input  wire         system_running,
	input  wire         discharging,
	input  wire  [15:0] charge_request,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [15:0] granted_current,
	output logic [2:0]  heat_zone,
	output logic        stop_charge,
	output logic        force_idle,
	output logic        sample_taken
);
	import tccl_pkg::*;

	localparam int SUM_W  = 8 + $clog2(WINDOW_LENGTH);
	localparam int NUM_W  = SUM_W + 2;
	localparam int ABS_W  = SUM_W + 1;
	localparam int DIV    = 2 * WINDOW_LENGTH;
	localparam int DIV_LG = $clog2(DIV);
	localparam int SHIFT  = ABS_W + DIV_LG + 1;
	localparam int MULT_W = SHIFT - DIV_LG + 1;
	localparam int PROD_W = ABS_W + MULT_W;
	localparam logic [MULT_W-1:0] MULT = MULT_W'(((1 << SHIFT) + DIV - 1) / DIV);
	localparam logic signed [NUM_W-1:0] ROUND = NUM_W'(WINDOW_LENGTH);

	// configuration registers
	logic [15:0] zone_one_q;
	logic [15:0] zone_two_q;
	logic [15:0] zone_three_q;
	celsius_t    cpu_gate_q;
	celsius_t    cutoff_q;
	logic [2:0]  reg_idx;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_one_q   <= RST_ZONE_ONE;
			zone_two_q   <= RST_ZONE_TWO;
			zone_three_q <= RST_ZONE_THREE;
			cpu_gate_q   <= RST_CPU_GATE;
			cutoff_q     <= RST_CUTOFF;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_ZONE_ONE:   zone_one_q   <= pwdata[15:0];
				REG_ZONE_TWO:   zone_two_q   <= pwdata[15:0];
				REG_ZONE_THREE: zone_three_q <= pwdata[15:0];
				REG_CPU_GATE:   cpu_gate_q   <= pwdata[7:0];
				REG_CUTOFF:     cutoff_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ZONE_ONE:   prdata = {16'd0, zone_one_q};
			REG_ZONE_TWO:   prdata = {16'd0, zone_two_q};
			REG_ZONE_THREE: prdata = {16'd0, zone_three_q};
			REG_CPU_GATE:   prdata = {{24{cpu_gate_q[7]}}, cpu_gate_q};
			REG_CUTOFF:     prdata = {{24{cutoff_q[7]}}, cutoff_q};
			default:        prdata = 32'd0;
		endcase
	end

	// pipeline control
	logic advance;
	logic accept;
	logic out_valid_q;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	// input decode
	logic     take_in;
	celsius_t sample_in;
	item_t    item_in;

	assign take_in   = battery_responsive && (charger_kelvin >= VALID_LOW_K)
		&& (charger_kelvin <= VALID_HIGH_K);
	assign sample_in = 8'(charger_kelvin - KELVIN_OFFSET);

	always_comb begin
		item_in.cpu_kelvin      = cpu_kelvin;
		item_in.bad_temperature = bad_temperature;
		item_in.system_running  = system_running;
		item_in.discharging     = discharging;
		item_in.charge_request  = charge_request;
		item_in.take            = take_in;
	end

	// window cells
	celsius_t                  cell_sample [WINDOW_LENGTH];
	logic signed [SUM_W-1:0]   cell_sum    [WINDOW_LENGTH];

	for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
		tccl_cell #(
			.SUM_W(SUM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (accept && take_in),
			.sample_in ((i == 0) ? sample_in : cell_sample[(i == 0) ? 0 : i - 1]),
			.sample_out(cell_sample[i]),
			.sum_in    ((i == 0) ? SUM_W'(0) : cell_sum[(i == 0) ? 0 : i - 1]),
			.sum_out   (cell_sum[i])
		);
	end

	// stage registers
	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	item_t                    item_s1;
	item_t                    item_s2;
	item_t                    item_s3;
	logic signed [SUM_W-1:0]  sum_s2;
	logic [7:0]               quot_s3;
	logic                     neg_s3;

	logic signed [NUM_W-1:0]  num;
	logic [ABS_W-1:0]         abs_num;
	logic [PROD_W-1:0]        prod;

	assign num     = (NUM_W'(sum_s2) <<< 1) + ROUND;
	assign abs_num = num[NUM_W-1] ? ABS_W'(-num) : ABS_W'(num);
	assign prod    = PROD_W'(abs_num) * PROD_W'(MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item_in;
			item_s2 <= item_s1;
			sum_s2  <= cell_sum[WINDOW_LENGTH-1];
			item_s3 <= item_s2;
			quot_s3 <= prod[SHIFT +: 8];
			neg_s3  <= num[NUM_W-1];
		end
	end

	// zoning
	celsius_t                 avg_s3;
	celsius_t                 prev_avg_q;
	logic signed [10:0]       cpu_c;
	logic signed [10:0]       gate_c;
	logic                     cut;
	logic                     gated;
	logic [2:0]               zone;
	logic [15:0]              limit;
	logic [15:0]              grant;

	assign avg_s3 = neg_s3 ? $signed(-quot_s3) : $signed(quot_s3);
	assign cpu_c  = $signed({1'b0, item_s3.cpu_kelvin}) - 11'sd273;
	assign gate_c = $signed({{3{cpu_gate_q[7]}}, cpu_gate_q});
	assign cut    = item_s3.bad_temperature || (avg_s3 > cutoff_q);
	assign gated  = item_s3.system_running && (cpu_c >= gate_c);

	always_comb begin
		zone = ZONE_NONE;
		if (cut) begin
			zone = ZONE_CUTOFF;
		end else if (gated) begin
			if (prev_avg_q <= avg_s3) begin
				if (avg_s3 >= RISE_ZONE3) zone = ZONE_THREE;
				else if (avg_s3 >= RISE_ZONE2) zone = ZONE_TWO;
				else if (avg_s3 >= RISE_ZONE1) zone = ZONE_ONE;
				else zone = ZONE_NONE;
			end else begin
				if (avg_s3 < FALL_ZONE1) zone = ZONE_NONE;
				else if (avg_s3 < FALL_ZONE2) zone = ZONE_ONE;
				else if (avg_s3 < FALL_ZONE3) zone = ZONE_TWO;
				else zone = ZONE_THREE;
			end
		end
	end

	always_comb begin
		case (zone)
			ZONE_ONE:    limit = zone_one_q;
			ZONE_TWO:    limit = zone_two_q;
			ZONE_THREE:  limit = zone_three_q;
			ZONE_CUTOFF: limit = 16'd0;
			default:     limit = item_s3.charge_request;
		endcase
		grant = (item_s3.charge_request < limit) ? item_s3.charge_request : limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_avg_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s3;
			if (v_s3 && item_s3.take) begin
				prev_avg_q <= avg_s3;
			end
		end
	end

	logic [15:0] granted_current_q;
	logic [2:0]  heat_zone_q;
	logic        stop_charge_q;
	logic        force_idle_q;
	logic        sample_taken_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (item_s3.take) begin
				granted_current_q <= grant;
				heat_zone_q       <= zone;
				stop_charge_q     <= (zone == ZONE_CUTOFF);
				force_idle_q      <= (zone == ZONE_CUTOFF) && !item_s3.discharging;
				sample_taken_q    <= 1'b1;
			end else begin
				granted_current_q <= item_s3.charge_request;
				heat_zone_q       <= ZONE_NONE;
				stop_charge_q     <= 1'b0;
				force_idle_q      <= 1'b0;
				sample_taken_q    <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign granted_current = granted_current_q;
	assign heat_zone       = heat_zone_q;
	assign stop_charge     = stop_charge_q;
	assign force_idle      = force_idle_q;
	assign sample_taken    = sample_taken_q;

	`TCCL_ASSERT_IMPL(a_cutoff_zero, clk, arst_n, out_valid && stop_charge, heat_zone == ZONE_CUTOFF && granted_current == 16'd0)
	`TCCL_ASSERT_IMPL(a_idle_needs_stop, clk, arst_n, out_valid && force_idle, stop_charge)
	`TCCL_ASSERT_IMPL(a_pass_no_zone, clk, arst_n, out_valid && !sample_taken, heat_zone == ZONE_NONE && !stop_charge)
	`TCCL_ASSERT_NEXT(a_prev_tracks, clk, arst_n, advance && v_s3 && item_s3.take, prev_avg_q == $past(avg_s3))

endmodule

`default_nettype wire

// ===== src/tccl_cell.sv =====
// ---------------------------------------------------------------------------
// tccl_cell
// One window slot: holds a sample, shifts to its neighbor, adds to the sum.
// ---------------------------------------------------------------------------
`default_nettype none

module tccl_cell #(
	parameter int SUM_W = 11
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       shift_en,
	input  wire tccl_pkg::celsius_t   sample_in,
	output tccl_pkg::celsius_t        sample_out,
	input  wire logic signed [SUM_W-1:0] sum_in,
	output logic signed [SUM_W-1:0]   sum_out
);
	import tccl_pkg::*;

	celsius_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= sample_in;
		end
	end

	assign sample_out = sample_q;
	assign sum_out    = sum_in + $signed({{(SUM_W-8){sample_q[7]}}, sample_q});

endmodule

`default_nettype wire
